// ----- sv/first_fit_extent_allocator_unit_defines.svh -----
// Assertion macros for the first-fit extent allocator checker.
// Used by ffa_checker.sv; no other dependencies.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define FFA_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("ffa assertion failed");

// next-cycle implication
`define FFA_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("ffa assertion failed");

`endif

// ----- sv/ffa_pkg.sv -----
// Shared types and codes for the first-fit extent allocator.
// No dependencies.
package ffa_pkg;

    localparam int OFF_W = 10;
    localparam int LEN_W = 11;

    // pool size the offset and length widths are built for
    localparam int POOL_WORDS = 1024;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_REALLOC = 2'd1;
    localparam logic [1:0] OP_FREE    = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_REMOVE = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_GROW   = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op               op;
        logic [OFF_W-1:0]       key;
        logic [OFF_W-1:0]       new_begin;
        logic [OFF_W-1:0]       new_end;
        logic [LEN_W-1:0]       size;
        logic [LEN_W-1:0]       live;
    } t_cell_cmd;

endpackage

// ----- sv/ffa_cell.sv -----
// One extent cell: holds begin/end, evaluates its gap and shifts with neighbours.
// Depends on ffa_pkg.
module ffa_cell
    import ffa_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_cmd        i_cmd,
    input  logic             i_valid,
    input  logic             i_valid_next,
    input  logic             i_at_count,
    input  logic             i_left_gt,
    input  logic [OFF_W-1:0] i_left_begin,
    input  logic [OFF_W-1:0] i_left_end,
    input  logic [OFF_W-1:0] i_right_begin,
    input  logic [OFF_W-1:0] i_right_end,
    output logic [OFF_W-1:0] o_begin,
    output logic [LEN_W-1:0] o_start,
    output logic             o_fit,
    output logic             o_match,
    output logic             o_gt,
    output logic             o_lt,
    output logic             o_big,
    output logic             o_room
);

    logic [OFF_W-1:0] r_begin, n_begin;
    logic [OFF_W-1:0] r_end, n_end;
    logic [LEN_W-1:0] lim, start, gap, room, size;

    always_comb begin
        lim   = i_valid_next ? {1'b0, i_right_begin} : i_cmd.live;
        start = {1'b0, r_end} + LEN_W'(1);
        gap   = (lim >= start) ? lim - start : '0;
        room  = (lim >= {1'b0, r_begin}) ? lim - {1'b0, r_begin} : '0;
        size  = {1'b0, r_end} - {1'b0, r_begin} + LEN_W'(1);
    end

    assign o_begin = r_begin;
    assign o_start = start;
    assign o_fit   = i_valid && (gap >= i_cmd.size);
    assign o_match = i_valid && (r_begin == i_cmd.key);
    assign o_gt    = i_valid && (r_begin > i_cmd.key);
    assign o_lt    = i_valid && (r_begin < i_cmd.key);
    assign o_big   = o_match && (size >= i_cmd.size);
    assign o_room  = o_match && (room >= i_cmd.size);

    always_comb begin
        n_begin = r_begin;
        n_end   = r_end;
        case (i_cmd.op)
            CELL_REMOVE: begin
                // every cell at or above the removed one pulls from the right
                if (i_valid && (r_begin >= i_cmd.key)) begin
                    n_begin = i_right_begin;
                    n_end   = i_right_end;
                end
            end
            CELL_INSERT: begin
                if (i_left_gt) begin
                    n_begin = i_left_begin;
                    n_end   = i_left_end;
                end else if (o_gt || i_at_count) begin
                    n_begin = i_cmd.new_begin;
                    n_end   = i_cmd.new_end;
                end
            end
            CELL_GROW: begin
                if (o_match) begin
                    n_end = i_cmd.new_end;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_begin <= n_begin;
        r_end   <= n_end;
    end

endmodule

// ----- sv/first_fit_extent_allocator_unit.sv -----
// Top level of the first-fit extent allocator: control sequencer over a row of ffa_cell.
// Depends on ffa_pkg and ffa_cell.
//
//  channel   dir  payload (low bit first)                      handshake
//  s_axis    in   opcode[1:0] request_size[12:2] offset[22:13]  tvalid/tready
//  m_axis    out  status[1:0] result_offset[11:2]              tvalid/tready
//  cfg       in   pool_length[10:0]                            i_cfg_we
//
// Each request passes the accepting cycle, an evaluation of all cells, the gap pick,
// then the shift passes along the cell row (none if rejected or the block is kept as
// is; one for allocate, grow, free; two for a moving reallocate), then the load of
// the output register.
// Synchronous active-low reset empties the table and sets pool_length to 1024.
// A stalled output holds the sequencer at its last step; input waits till idle.
module first_fit_extent_allocator_unit
    import ffa_pkg::*;
#(
    parameter int MAX_EXTENTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // opcode, request_size, block_offset
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // status, result_offset
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata
);

    localparam int CW     = $clog2(MAX_EXTENTS + 1);
    localparam int PW_CAP = (POOL_WORDS > 2047) ? 2047 : POOL_WORDS;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EVAL   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_REMOVE = 6'b001000,
        S_INSERT = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [LEN_W-1:0] r_pool, live;
    logic [CW-1:0]    r_count, n_count;
    logic [1:0]       r_op;
    logic [LEN_W-1:0] r_size;
    logic [OFF_W-1:0] r_key, n_key, r_off;
    logic [OFF_W-1:0] r_newb, n_newb, r_newe, n_newe;
    logic [1:0]       r_st, n_st;
    logic [OFF_W-1:0] r_res, n_res;
    logic             r_then_ins, n_then_ins, r_grow, n_grow;
    logic             r_ov;
    logic [1:0]       r_ost;
    logic [OFF_W-1:0] r_ooff;

    logic [MAX_EXTENTS-1:0] r_fit, r_gt, r_lt, r_match, r_big, r_room;
    logic [MAX_EXTENTS-1:0] c_fit, c_gt, c_lt, c_match, c_big, c_room;
    logic [MAX_EXTENTS-1:0] c_valid, c_at;
    logic [OFF_W-1:0]       c_begin [MAX_EXTENTS];
    logic [LEN_W-1:0]       c_start [MAX_EXTENTS];
    logic [OFF_W-1:0]       c_end   [MAX_EXTENTS];

    t_cell_cmd        cmd;
    logic [LEN_W-1:0] lim0;
    logic             front_fit;
    logic [MAX_EXTENTS:0] cand_a, cand_b, csel, oh;
    logic [LEN_W-1:0] sel_start;

    assign live = (r_pool > LEN_W'(PW_CAP)) ? LEN_W'(PW_CAP) : r_pool;

    always_comb begin
        for (int i = 0; i < MAX_EXTENTS; i++) begin
            c_valid[i] = (CW'(i) < r_count);
            c_at[i]    = (CW'(i) == r_count);
            c_end[i]   = OFF_W'(c_start[i] - LEN_W'(1));
        end
    end

    always_comb begin
        cmd.key       = r_key;
        cmd.new_begin = r_newb;
        cmd.new_end   = r_newe;
        cmd.size      = r_size;
        cmd.live      = live;
        case (r_state)
            S_REMOVE: cmd.op = CELL_REMOVE;
            S_INSERT: cmd.op = r_grow ? CELL_GROW : CELL_INSERT;
            default:  cmd.op = CELL_HOLD;
        endcase
    end

    for (genvar g = 0; g < MAX_EXTENTS; g++) begin : g_cell
        localparam int L = (g == 0) ? 0 : g - 1;
        localparam int R = (g == MAX_EXTENTS - 1) ? g : g + 1;
        ffa_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cmd),
            .i_valid      (c_valid[g]),
            .i_valid_next ((g == MAX_EXTENTS - 1) ? 1'b0 : c_valid[R]),
            .i_at_count   (c_at[g]),
            .i_left_gt    ((g == 0) ? 1'b0 : c_gt[L]),
            .i_left_begin (c_begin[L]),
            .i_left_end   (c_end[L]),
            .i_right_begin(c_begin[R]),
            .i_right_end  (c_end[R]),
            .o_begin      (c_begin[g]),
            .o_start      (c_start[g]),
            .o_fit        (c_fit[g]),
            .o_match      (c_match[g]),
            .o_gt         (c_gt[g]),
            .o_lt         (c_lt[g]),
            .o_big        (c_big[g]),
            .o_room       (c_room[g])
        );
    end

    // gap selection over the registered cell flags; bit 0 is the pool front
    always_comb begin
        lim0      = (r_count != '0) ? {1'b0, c_begin[0]} : live;
        front_fit = (lim0 >= r_size);
        cand_a    = {r_fit & r_gt, 1'b0};
        cand_b    = {r_fit & r_lt, front_fit};
        if (r_op == OP_ALLOC) begin
            csel = {r_fit, front_fit};
        end else if (|cand_a) begin
            csel = cand_a;
        end else begin
            csel = cand_b;
        end
        oh        = csel & (~csel + 1'b1);
        sel_start = '0;
        for (int i = 0; i < MAX_EXTENTS; i++) begin
            sel_start = sel_start | (oh[i+1] ? c_start[i] : '0);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_key      = r_key;
        n_newb     = r_newb;
        n_newe     = r_newe;
        n_st       = r_st;
        n_res      = r_res;
        n_then_ins = r_then_ins;
        n_grow     = r_grow;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_EVAL;
                    n_key   = s_axis_tdata[22:13];
                    n_grow  = 1'b0;
                end
            end
            S_EVAL: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state    = S_DONE;
                n_st       = ST_INVALID;
                n_res      = '0;
                n_then_ins = 1'b0;
                n_newb     = OFF_W'(sel_start);
                n_newe     = OFF_W'(sel_start + r_size - LEN_W'(1));
                case (r_op)
                    OP_ALLOC: begin
                        if (r_size == '0) begin
                            n_st = ST_INVALID;
                        end else if (r_count >= CW'(MAX_EXTENTS)) begin
                            n_st = ST_FULL;
                        end else if (!(|csel)) begin
                            n_st = ST_NOSPACE;
                        end else begin
                            n_st    = ST_OK;
                            n_res   = OFF_W'(sel_start);
                            n_key   = OFF_W'(sel_start);
                            n_state = S_INSERT;
                        end
                    end
                    OP_REALLOC: begin
                        if (!(|r_match)) begin
                            n_st = ST_INVALID;
                        end else if (|r_big) begin
                            n_st  = ST_OK;
                            n_res = r_off;
                        end else if (|r_room) begin
                            // grow in place
                            n_st    = ST_OK;
                            n_res   = r_off;
                            n_newe  = OFF_W'({1'b0, r_off} + r_size - LEN_W'(1));
                            n_grow  = 1'b1;
                            n_state = S_INSERT;
                        end else if (!(|csel)) begin
                            n_st = ST_NOSPACE;
                        end else begin
                            n_st       = ST_OK;
                            n_res      = OFF_W'(sel_start);
                            n_then_ins = 1'b1;
                            n_state    = S_REMOVE;
                        end
                    end
                    OP_FREE: begin
                        if (|r_match) begin
                            n_st    = ST_OK;
                            n_res   = r_off;
                            n_state = S_REMOVE;
                        end
                    end
                    default: begin
                        n_st = ST_INVALID;
                    end
                endcase
            end
            S_REMOVE: begin
                n_count = r_count - CW'(1);
                if (r_then_ins) begin
                    n_key   = r_newb;
                    n_state = S_INSERT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_INSERT: begin
                if (!r_grow) begin
                    n_count = r_count + CW'(1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pool  <= LEN_W'(1024);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_pool <= i_cfg_wdata;
            end
            if ((r_state == S_DONE) && (!r_ov || m_axis_tready)) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_newb     <= n_newb;
        r_newe     <= n_newe;
        r_st       <= n_st;
        r_res      <= n_res;
        r_then_ins <= n_then_ins;
        r_grow     <= n_grow;
        if ((r_state == S_IDLE) && s_axis_tvalid) begin
            r_op   <= s_axis_tdata[1:0];
            r_size <= s_axis_tdata[12:2];
            r_off  <= s_axis_tdata[22:13];
        end
        if (r_state == S_EVAL) begin
            r_fit   <= c_fit;
            r_gt    <= c_gt;
            r_lt    <= c_lt;
            r_match <= c_match;
            r_big   <= c_big;
            r_room  <= c_room;
        end
        if ((r_state == S_DONE) && (!r_ov || m_axis_tready)) begin
            r_ost  <= r_st;
            r_ooff <= r_res;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {4'd0, r_ooff, r_ost};

endmodule

// ----- sv/ffa_checker.sv -----
// Port-level checker for first_fit_extent_allocator_unit, bound to the top level.
// Depends on first_fit_extent_allocator_unit_defines.svh.
`include "first_fit_extent_allocator_unit_defines.svh"

module ffa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // stalled result item holds
    `FFA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // a failed status carries a zero offset
    `FFA_ASSERT_NOW(a_fail_zero, m_axis_tvalid && (m_axis_tdata[1:0] != 2'd0), m_axis_tdata[11:2] == 10'd0)
    // one item at a time: an accepted item closes the input for the next cycle
    `FFA_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // padding bits stay zero
    `FFA_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[15:12] == 4'd0)

endmodule

bind first_fit_extent_allocator_unit ffa_checker u_ffa_checker (.*);

// ----- sim/first_fit_extent_allocator_unit_tb.sv -----
// Self-checking testbench for first_fit_extent_allocator_unit: streams allocate, reallocate,
// free and invalid-opcode requests, predicts each status and offset from its own extent table.
// Depends on ffa_pkg and the allocator RTL.
module first_fit_extent_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ffa_pkg::*;

    localparam int POOL_MAX  = 1024;
    localparam int EXT_MAX   = 32;
    localparam int WDOG_MAX  = 20000;

    // lowest field last, to match the tdata packing
    typedef struct packed {
        logic [9:0]  off;
        logic [10:0] size;
        logic [1:0]  op;
    } t_req;

    typedef struct packed {
        logic [9:0] off;
        logic [1:0] st;
    } t_rsp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [10:0] i_cfg_wdata = '0;

    first_fit_extent_allocator_unit uut (.*);

    // predictor state
    int unsigned ext_begin [EXT_MAX];
    int unsigned ext_end [EXT_MAX];
    int unsigned ext_cnt;
    int unsigned pool_len;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   fail_cnt = 0;
    int   idle_cycles = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   stall_phase = 0;
    int   stall_mode = 0;
    // live block offsets, used to aim reallocate and free at real extents
    int unsigned live_offs[$];

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned live_words();
        return pool_len > POOL_MAX ? POOL_MAX : pool_len;
    endfunction

    function automatic int unsigned gap_words(int i, output int unsigned s);
        int unsigned lim;
        s = (i < 0) ? 0 : ext_end[i] + 1;
        lim = (i + 1 < int'(ext_cnt)) ? ext_begin[i + 1] : live_words();
        return lim >= s ? lim - s : 0;
    endfunction

    function automatic int find_extent(int unsigned off);
        for (int i = 0; i < int'(ext_cnt); i++)
            if (ext_begin[i] == off) return i;
        return -1;
    endfunction

    function automatic void drop_extent(int j);
        for (int i = j; i + 1 < int'(ext_cnt); i++) begin
            ext_begin[i] = ext_begin[i + 1];
            ext_end[i] = ext_end[i + 1];
        end
        ext_cnt--;
    endfunction

    function automatic void add_extent(int unsigned b, int unsigned e);
        int i;
        i = ext_cnt;
        if (ext_cnt >= EXT_MAX) return;
        while (i > 0 && ext_begin[i - 1] > b) begin
            ext_begin[i] = ext_begin[i - 1];
            ext_end[i] = ext_end[i - 1];
            i--;
        end
        ext_begin[i] = b;
        ext_end[i] = e;
        ext_cnt++;
    endfunction

    function automatic t_rsp predict_placement(t_req r);
        t_rsp        res;
        int          j;
        int unsigned s, b, room, n;
        bit          found;
        res = '{st: ST_OK, off: '0};
        n = r.size;
        found = 1'b0;
        if (r.op == OP_ALLOC) begin
            if (n == 0) res.st = ST_INVALID;
            else if (ext_cnt >= EXT_MAX) res.st = ST_FULL;
            else begin
                for (int i = -1; i < int'(ext_cnt) && !found; i++)
                    if (gap_words(i, s) >= n) found = 1'b1;
                if (found) begin
                    add_extent(s, s + n - 1);
                    res.off = 10'(s);
                end else res.st = ST_NOSPACE;
            end
        end else if (r.op == OP_REALLOC) begin
            j = find_extent(r.off);
            if (j < 0) res.st = ST_INVALID;
            else begin
                b = ext_begin[j];
                if (ext_end[j] - b + 1 >= n) res.off = 10'(b);
                else begin
                    if (j + 1 < int'(ext_cnt)) room = ext_begin[j + 1] - b;
                    else room = live_words() >= b ? live_words() - b : 0;
                    if (room >= n) begin
                        ext_end[j] = b + n - 1;
                        res.off = 10'(b);
                    end else begin
                        for (int i = j + 1; i < int'(ext_cnt) && !found; i++)
                            if (gap_words(i, s) >= n) found = 1'b1;
                        for (int i = -1; i < j && !found; i++)
                            if (gap_words(i, s) >= n) found = 1'b1;
                        if (found) begin
                            drop_extent(j);
                            add_extent(s, s + n - 1);
                            res.off = 10'(s);
                        end else res.st = ST_NOSPACE;
                    end
                end
            end
        end else if (r.op == OP_FREE) begin
            j = find_extent(r.off);
            if (j < 0) res.st = ST_INVALID;
            else begin
                drop_extent(j);
                res.off = r.off;
            end
        end else res.st = ST_INVALID;
        return res;
    endfunction

    // queue a request; the prediction is made at acceptance
    task automatic push_req(logic [1:0] op, int unsigned size, int unsigned off);
        t_req r;
        r.op = op;
        r.size = size[10:0];
        r.off = off[9:0];
        pending_reqs.push_back(r);
    endtask

    // random request, mostly aimed at live extents; live_offs updated by the driver at acceptance
    task automatic push_random();
        int          k;
        int unsigned off, sz;
        k = $urandom_range(0, 99);
        sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 96);
        off = $urandom_range(0, 1023);
        if (live_offs.size() > 0 && $urandom_range(0, 9) < 8)
            off = live_offs[$urandom_range(0, live_offs.size() - 1)];
        if (k < 45) push_req(OP_ALLOC, sz, off);
        else if (k < 70) push_req(OP_REALLOC, sz, off);
        else if (k < 97) push_req(OP_FREE, sz, off);
        else push_req(2'd3, sz, off);
    endtask

    // driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                t_req   r;
                r = s_axis_tdata[22:0];
                expected_rsps.push_back(predict_placement(r));
                if (r.op != 2'd3) begin
                    live_offs.delete();
                    for (int i = 0; i < int'(ext_cnt); i++) live_offs.push_back(ext_begin[i]);
                end
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                s_axis_tdata <= {1'b0, pending_reqs.pop_front()};
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0) burst_left <= burst_left - 1;
                else begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern: one of four ready modes, re-chosen at random from the phase counter
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            2: m_axis_tready <= (stall_phase % 7) < 2;
            default: m_axis_tready <= $urandom_range(0, 7) == 0;
        endcase
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_rsp got, want;
            got = m_axis_tdata[11:0];
            if (expected_rsps.size() == 0) begin
                $display("%0t: unexpected result st=%0d off=%0d", $time, got.st, got.off);
                fail_cnt++;
            end else begin
                want = expected_rsps.pop_front();
                if (got.st !== want.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
                    fail_cnt++;
                end
                if (got.off !== want.off) begin
                    $display("%0t: offset expected %0d actual %0d", $time, want.off, got.off);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (i_rst_n) idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("first_fit_extent_allocator_unit: mismatch");
            $finish;
        end
    end

    // sampled at the falling edge so the driver's updates have settled
    task automatic drain();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_rsps.size() > 0)
            @(negedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_pool_length(int unsigned v);
        i_cfg_wdata <= v[10:0];
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pool_len = v;
        @(posedge i_clk);
    endtask

    initial begin
        int unsigned lens [6];
        pool_len = 1024;
        ext_cnt = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every opcode, each corner
        write_pool_length(2047);
        push_req(OP_ALLOC, 0, 0);
        push_req(OP_ALLOC, 2047, 1023);
        push_req(OP_ALLOC, 1024, 0);
        push_req(OP_FREE, 0, 0);
        push_req(OP_FREE, 0, 0);
        push_req(2'd3, 2047, 1023);
        push_req(OP_ALLOC, 10, 0);
        push_req(OP_ALLOC, 20, 0);
        push_req(OP_ALLOC, 30, 0);
        push_req(OP_REALLOC, 0, 10);
        push_req(OP_REALLOC, 40, 10);
        push_req(OP_REALLOC, 5, 0);
        push_req(OP_REALLOC, 50, 1023);
        push_req(OP_REALLOC, 2000, 0);
        push_req(OP_FREE, 0, 30);
        push_req(OP_REALLOC, 980, 0);
        push_req(OP_FREE, 1234, 77);
        drain();
        for (int i = 0; i < 34; i++) push_req(OP_ALLOC, 1, 0);
        push_req(OP_FREE, 0, 5);
        push_req(OP_REALLOC, 3, 4);
        drain();
        write_pool_length(0);
        push_req(OP_ALLOC, 1, 0);
        push_req(OP_REALLOC, 2, 0);
        drain();

        lens = '{1024, 64, 1, 300, 2047, 1000};
        for (int ph = 0; ph < 6; ph++) begin
            write_pool_length(lens[ph]);
            for (int i = 0; i < 320; i++) push_random();
            drain();
        end

        if (fail_cnt == 0) $display("first_fit_extent_allocator_unit: match");
        else $display("first_fit_extent_allocator_unit: mismatch");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+sv
sv/ffa_pkg.sv
sv/ffa_cell.sv
sv/first_fit_extent_allocator_unit.sv
sv/ffa_checker.sv
sim/first_fit_extent_allocator_unit_tb.sv
